// ----- design/fbsa_pkg.sv -----
// Shared types, codes and helpers of the free block stack allocator.
package fbsa_pkg;

  localparam int BlockW            = 16;
  localparam int RefillSlotW       = 5;
  localparam int StackDepthDefault = 32;
  localparam int QueueDepth        = 2;

  // Configuration register indexes
  localparam logic CFG_DATA_AREA_START    = 1'b0;
  localparam logic CFG_VOLUME_BLOCK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE       = 2'd1,
    OP_REFILL_CNT = 2'd2,
    OP_REFILL_ENT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  typedef struct packed {
    logic [BlockW-1:0] data_area_start;
    logic [BlockW-1:0] volume_block_count;
  } cfg_t;

  typedef struct packed {
    op_e                    op;
    logic                   bad;
    logic [BlockW-1:0]      blk;
    logic [BlockW-1:0]      val;
    logic [RefillSlotW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [BlockW-1:0] blk;
    logic              refill;
    logic              spill_valid;
    logic [BlockW-1:0] spill_word;
    logic              last;
  } res_t;

  function automatic logic is_bad(logic [BlockW-1:0] blk, cfg_t cfg);
    return (blk < cfg.data_area_start) || (blk >= cfg.volume_block_count);
  endfunction

endpackage

// ----- design/fbsa_front.sv -----
// Front end: configuration registers, input acceptance and command classification.
module fbsa_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output fbsa_pkg::cfg_t       cfg_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output fbsa_pkg::cmd_t       q_cmd_o
);

  fbsa_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        fbsa_pkg::CFG_DATA_AREA_START:    cfg_d.data_area_start    = cfg_data_i;
        fbsa_pkg::CFG_VOLUME_BLOCK_COUNT: cfg_d.volume_block_count = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.data_area_start    <= 16'd2;
      cfg_q.volume_block_count <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // Classify: decode the operation and check a freed block against the volume bounds
  always_comb begin
    q_cmd_o.op   = fbsa_pkg::op_e'(s_axis_tuser);
    q_cmd_o.blk  = s_axis_tdata[15:0];
    q_cmd_o.val  = s_axis_tdata[31:16];
    q_cmd_o.slot = s_axis_tdata[36:32];
    q_cmd_o.bad  = fbsa_pkg::is_bad(s_axis_tdata[15:0], cfg_q);
  end

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

endmodule

// ----- design/fbsa_cmd_queue.sv -----
// Short command queue between the front end and the stack engine.
module fbsa_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fbsa_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output fbsa_pkg::cmd_t cmd_o,
  input  logic           pop_i
);

  localparam int PtrW = $clog2(fbsa_pkg::QueueDepth);
  localparam int CntW = $clog2(fbsa_pkg::QueueDepth + 1);

  fbsa_pkg::cmd_t    slot_q [fbsa_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(fbsa_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(fbsa_pkg::QueueDepth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(fbsa_pkg::QueueDepth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/fbsa_back.sv -----
// Stack engine: free count, entry memory, pop, push, spill and refill, output register.
module fbsa_back #(
  parameter int StackDepth = fbsa_pkg::StackDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fbsa_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  fbsa_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output fbsa_pkg::res_t res_o
);

  localparam int AddrW    = $clog2(StackDepth);
  localparam int CountW   = $clog2(StackDepth + 1);
  localparam int BlockW   = fbsa_pkg::BlockW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SPILL_CNT,
    S_SPILL,
    S_PUSH
  } state_e;

  state_e             state_q, state_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  fbsa_pkg::cmd_t     cmd_q, cmd_d;
  logic               out_valid_q, out_valid_d;
  fbsa_pkg::res_t     out_q, out_d;

  logic [BlockW-1:0]  mem_q [StackDepth];
  logic [BlockW-1:0]  rd_data_q;
  logic               wr_en, rd_en;
  logic [AddrW-1:0]   wr_addr, rd_addr;
  logic [BlockW-1:0]  wr_data;

  logic               emit_ok;
  logic [CountW-1:0]  count_m1;
  logic [CountW-1:0]  count_p1;
  logic [CountW-1:0]  refill_count;
  logic [AddrW-1:0]   slot_addr;
  logic               slot_in_range;
  fbsa_pkg::res_t     res;

  assign emit_ok  = !out_valid_q || res_ready_i;
  assign count_m1 = CountW'(count_q - 1'b1);
  assign count_p1 = CountW'(count_q + 1'b1);
  assign refill_count = (q_cmd_i.val > BlockW'(StackDepth)) ? CountW'(StackDepth)
                                                             : q_cmd_i.val[CountW-1:0];
  assign slot_in_range = (int'(q_cmd_i.slot) < StackDepth);
  assign slot_addr     = AddrW'(q_cmd_i.slot);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    res         = '0;
    res.status  = fbsa_pkg::ST_OK;
    res.last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            fbsa_pkg::OP_ALLOC: begin
              if (count_q == '0) begin
                if (emit_ok) begin
                  q_pop_o     = 1'b1;
                  res.status  = fbsa_pkg::ST_NOSPACE;
                  out_d       = res;
                  out_valid_d = 1'b1;
                end
              end else begin
                // Pop: fetch the top entry into the read register; S_POP answers with it
                q_pop_o = 1'b1;
                count_d = count_m1;
                rd_en   = 1'b1;
                rd_addr = count_m1[AddrW-1:0];
                state_d = S_POP;
              end
            end
            fbsa_pkg::OP_FREE: begin
              if (q_cmd_i.bad) begin
                if (emit_ok) begin
                  q_pop_o     = 1'b1;
                  res.status  = fbsa_pkg::ST_BAD;
                  res.blk     = q_cmd_i.blk;
                  out_d       = res;
                  out_valid_d = 1'b1;
                end
              end else begin
                q_pop_o = 1'b1;
                cmd_d   = q_cmd_i;
                if (count_q == '0) begin
                  // Empty stack: place the zero end marker in slot 0
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = '0;
                  count_d = CountW'(1);
                  state_d = S_PUSH;
                end else if (count_q >= CountW'(StackDepth)) begin
                  state_d = S_SPILL_CNT;
                end else begin
                  state_d = S_PUSH;
                end
              end
            end
            fbsa_pkg::OP_REFILL_CNT: begin
              if (emit_ok) begin
                q_pop_o     = 1'b1;
                count_d     = refill_count;
                out_d       = res;
                out_valid_d = 1'b1;
              end
            end
            fbsa_pkg::OP_REFILL_ENT: begin
              if (emit_ok) begin
                q_pop_o     = 1'b1;
                wr_en       = slot_in_range;
                wr_addr     = slot_addr;
                wr_data     = q_cmd_i.val;
                out_d       = res;
                out_valid_d = 1'b1;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        if (emit_ok) begin
          if (rd_data_q == '0) begin
            res.status = fbsa_pkg::ST_NOSPACE;
          end else begin
            res.status = fbsa_pkg::is_bad(rd_data_q, cfg_i) ? fbsa_pkg::ST_BAD
                                                              : fbsa_pkg::ST_OK;
            res.blk    = rd_data_q;
            res.refill = (count_q == '0);
          end
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SPILL_CNT: begin
        if (emit_ok) begin
          res.blk         = cmd_q.blk;
          res.spill_valid = 1'b1;
          res.spill_word  = BlockW'(count_q);
          res.last        = 1'b0;
          out_d           = res;
          out_valid_d     = 1'b1;
          rd_en           = 1'b1;
          rd_addr         = '0;
          idx_d           = '0;
          state_d         = S_SPILL;
        end
      end
      S_SPILL: begin
        if (emit_ok) begin
          res.blk         = cmd_q.blk;
          res.spill_valid = 1'b1;
          res.spill_word  = rd_data_q;
          res.last        = 1'b0;
          out_d           = res;
          out_valid_d     = 1'b1;
          if (idx_q == AddrW'(StackDepth - 1)) begin
            count_d = '0;
            state_d = S_PUSH;
          end else begin
            // Advance: fetch the next entry while this word goes out
            rd_en   = 1'b1;
            rd_addr = AddrW'(idx_q + 1'b1);
            idx_d   = AddrW'(idx_q + 1'b1);
          end
        end
      end
      S_PUSH: begin
        if (emit_ok) begin
          wr_en       = 1'b1;
          wr_addr     = count_q[AddrW-1:0];
          wr_data     = cmd_q.blk;
          count_d     = count_p1;
          res.blk     = cmd_q.blk;
          out_d       = res;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read, so a stalled output keeps its word
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- design/free_block_stack_allocator.sv -----
// Top level of the free block stack allocator.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------------
//  s_axis   | in        | tvalid / tready       | tuser: operation; tdata: block_in,
//           |           |                       |   refill_value, refill_slot
//  m_axis   | out       | tvalid / tready       | tuser: status, spill_valid; tdata:
//           |           |                       |   block_out, refill_needed, spill_word;
//           |           |                       |   tlast: last
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index_i, cfg_data_i (always ready)
//
// The front end accepts one item per cycle, unless the two-entry command queue is full.
// The stack engine takes one command at a time. An allocate from a nonempty stack passes
// through S_POP (the stack memory read is registered), a good free through S_PUSH; refills,
// bad frees and allocates from an empty stack answer from S_IDLE. A free into a full stack
// spills STACK_DEPTH + 1 words, one spill word per cycle; m_axis stalls hold the engine in place.
// After reset the count is zero; the entry memory needs no clearing pass.
module free_block_stack_allocator #(
  parameter int STACK_DEPTH = fbsa_pkg::StackDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [15:0] block_in, [31:16] refill_value,
                                     // [36:32] refill_slot, [39:37] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [15:0] block_out, [16] refill_needed,
                                     // [32:17] spill_word, [39:33] zero
  output logic [2:0]  m_axis_tuser,  // [1:0] status, [2] spill_valid
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  fbsa_pkg::cfg_t cfg;
  fbsa_pkg::cmd_t push_cmd, head_cmd;
  fbsa_pkg::res_t res;
  logic           q_full, q_push, q_valid, q_pop;

  fbsa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_o         (cfg),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  fbsa_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (q_pop)
  );

  fbsa_back #(
    .StackDepth (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'b0, res.spill_word, res.refill, res.blk};
  assign m_axis_tuser = {res.spill_valid, res.status};
  assign m_axis_tlast = res.last;

endmodule

// ----- design/fbsa_checker.sv -----
// Port-level checks of the free block stack allocator, bound to the top level.
module fbsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
  else $error("result changed while stalled");

  // Spill words are never the final result and always report ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      !m_axis_tlast && (m_axis_tuser[1:0] == fbsa_pkg::ST_OK))
  else $error("spill word with bad framing or status");

  // Refill request only on a single allocate result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |->
      m_axis_tlast && !m_axis_tuser[2] && (m_axis_tuser[1:0] != fbsa_pkg::ST_NOSPACE))
  else $error("refill request on a wrong result");

  // No space carries no block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] == fbsa_pkg::ST_NOSPACE) |->
      (m_axis_tdata[15:0] == 16'd0) && m_axis_tlast)
  else $error("no-space result with a block number");

endmodule

bind free_block_stack_allocator fbsa_checker u_fbsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the free block stack allocator: directed and random traffic.
`timescale 1ns / 1ps

module tb_top;

  localparam int STACK_DEPTH = fbsa_pkg::StackDepthDefault;
  localparam int SlotW       = $clog2(STACK_DEPTH);
  localparam int CYCLE_LIMIT = 500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [15:0] block_in, [31:16] refill_value, [36:32] refill_slot
  logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [15:0] block_out, [16] refill_needed, [32:17] spill_word
  logic [2:0]  m_axis_tuser;        // [1:0] status, [2] spill_valid
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  // Mirror of the block: layout registers and the cached free stack
  logic [15:0]    area_start = 16'd2;
  logic [15:0]    volume_size = 16'd0;
  logic [5:0]     stack_count = '0;
  logic [15:0]    stack_words [STACK_DEPTH];
  bit             slot_written [STACK_DEPTH];
  fbsa_pkg::res_t expected_results [$];

  bit idling_on = 1'b1;
  int stall_left = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int spill_runs = 0;
  int reload_requests = 0;
  int layouts_used = 0;

  free_block_stack_allocator #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit outside_volume(logic [15:0] blk);
    return (blk < area_start) || (blk >= volume_size);
  endfunction

  function automatic logic [15:0] good_block();
    if (volume_size > area_start) return 16'($urandom_range(area_start, volume_size - 1));
    return 16'($urandom);
  endfunction

  function automatic void expect_result(fbsa_pkg::status_e st, logic [15:0] blk,
                                        logic refill, logic spill, logic [15:0] word,
                                        logic last);
    fbsa_pkg::res_t r;
    r.status      = st;
    r.blk         = blk;
    r.refill      = refill;
    r.spill_valid = spill;
    r.spill_word  = word;
    r.last        = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_stack(fbsa_pkg::op_e op, logic [15:0] blk,
                                        logic [15:0] val, logic [4:0] slot);
    logic [15:0] popped;
    case (op)
      fbsa_pkg::OP_ALLOC: begin
        if (stack_count == 0) begin
          expect_result(fbsa_pkg::ST_NOSPACE, '0, 1'b0, 1'b0, '0, 1'b1);
        end else begin
          stack_count--;
          popped = stack_words[SlotW'(stack_count)];
          if (popped == 0) begin
            expect_result(fbsa_pkg::ST_NOSPACE, '0, 1'b0, 1'b0, '0, 1'b1);
          end else begin
            if (stack_count == 0) reload_requests++;
            expect_result(outside_volume(popped) ? fbsa_pkg::ST_BAD : fbsa_pkg::ST_OK, popped,
                          stack_count == 0, 1'b0, '0, 1'b1);
          end
        end
      end
      fbsa_pkg::OP_FREE: begin
        if (outside_volume(blk)) begin
          expect_result(fbsa_pkg::ST_BAD, blk, 1'b0, 1'b0, '0, 1'b1);
        end else begin
          // an empty stack gets a zero end-of-chain marker at the bottom
          if (stack_count == 0) begin
            stack_count = 1;
            stack_words[0] = '0;
            slot_written[0] = 1'b1;
          end
          if (stack_count >= STACK_DEPTH) begin
            spill_runs++;
            expect_result(fbsa_pkg::ST_OK, blk, 1'b0, 1'b1, 16'(stack_count), 1'b0);
            for (int i = 0; i < STACK_DEPTH; i++)
              expect_result(fbsa_pkg::ST_OK, blk, 1'b0, 1'b1, stack_words[SlotW'(i)], 1'b0);
            stack_count = 0;
          end
          stack_words[SlotW'(stack_count)] = blk;
          slot_written[SlotW'(stack_count)] = 1'b1;
          stack_count++;
          expect_result(fbsa_pkg::ST_OK, blk, 1'b0, 1'b0, '0, 1'b1);
        end
      end
      fbsa_pkg::OP_REFILL_CNT: begin
        stack_count = (val > STACK_DEPTH) ? 6'(STACK_DEPTH) : 6'(val);
        expect_result(fbsa_pkg::ST_OK, '0, 1'b0, 1'b0, '0, 1'b1);
      end
      default: begin
        if (slot < STACK_DEPTH) begin
          stack_words[slot] = val;
          slot_written[slot] = 1'b1;
        end
        expect_result(fbsa_pkg::ST_OK, '0, 1'b0, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic issue(input fbsa_pkg::op_e op, input logic [15:0] blk,
                       input logic [15:0] val, input logic [4:0] slot);
    int gap;
    // never pop or spill an entry that was not loaded: load it instead
    if (op == fbsa_pkg::OP_ALLOC && stack_count != 0
        && !slot_written[SlotW'(stack_count - 1)]) begin
      op = fbsa_pkg::OP_REFILL_ENT;
      slot = 5'(stack_count - 1);
    end else if (op == fbsa_pkg::OP_FREE && !outside_volume(blk)
                 && stack_count >= STACK_DEPTH) begin
      for (int k = STACK_DEPTH - 1; k >= 0; k--)
        if (!slot_written[SlotW'(k)]) begin
          op = fbsa_pkg::OP_REFILL_ENT;
          slot = 5'(k);
        end
    end
    predict_stack(op, blk, val, slot);
    items_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, slot, val, blk};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic do_alloc();
    issue(fbsa_pkg::OP_ALLOC, 16'($urandom), 16'($urandom), 5'($urandom));
  endtask

  task automatic do_free(input logic [15:0] blk);
    issue(fbsa_pkg::OP_FREE, blk, 16'($urandom), 5'($urandom));
  endtask

  task automatic do_refill_count(input logic [15:0] val);
    issue(fbsa_pkg::OP_REFILL_CNT, 16'($urandom), val, 5'($urandom));
  endtask

  task automatic do_refill_entry(input logic [4:0] slot, input logic [15:0] val);
    issue(fbsa_pkg::OP_REFILL_ENT, 16'($urandom), val, slot);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == fbsa_pkg::CFG_DATA_AREA_START) area_start = value;
    else volume_size = value;
  endtask

  task automatic set_layout(input logic [15:0] first_data, input logic [15:0] total);
    wait_drained();
    write_register(fbsa_pkg::CFG_DATA_AREA_START, first_data);
    write_register(fbsa_pkg::CFG_VOLUME_BLOCK_COUNT, total);
    layouts_used++;
  endtask

  // Layout out of reset: no block lies inside the volume
  task automatic test_reset_layout();
    do_alloc();
    do_free(16'h0000);
    do_free(16'hFFFF);
    do_free(16'd2);
    do_refill_entry(5'd0, 16'h0000);
    do_refill_count(16'h0000);
  endtask

  task automatic test_single_ops();
    set_layout(16'h0000, 16'hFFFF);
    do_free(16'h0000);            // block zero is valid here; it pops as no space
    do_alloc();
    do_alloc();                   // end-of-chain marker
    do_free(16'hFFFF);
    do_free(16'hFFFE);
    do_alloc();
    do_refill_entry(5'd0, 16'hFFFF);
    do_refill_entry(5'd31, 16'hFFFF);
    do_refill_count(16'd1);
    do_alloc();                   // bottom pop of an out-of-range block
    do_refill_count(16'hFFFF);    // saturates at the depth
    do_alloc();
    do_refill_count(16'd0);
    do_alloc();
    do_refill_entry(5'd0, 16'h1234);
    do_refill_count(16'd1);
    do_alloc();
    set_layout(16'hFFFF, 16'hFFFF);
    do_free(16'hFFFF);
    do_free(16'h0000);
    do_refill_count(16'd1);
    do_alloc();
    set_layout(16'h0000, 16'h0000);
    do_free(16'h0000);
  endtask

  // Fill the stack by frees until one spills it, then take a few back
  task automatic test_spill_run();
    set_layout(16'd16, 16'd4096);
    do_refill_count(16'd0);
    repeat (STACK_DEPTH + 2) do_free(good_block());
    repeat (3) do_alloc();
  endtask

  task automatic test_mixed_traffic(input int item_goal);
    int start_count;
    int kind;
    int n;
    start_count = items_sent;
    while (items_sent - start_count < item_goal) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        n = $urandom_range(1, 12);
        repeat (n) do_free(($urandom_range(0, 7) == 0) ? 16'($urandom) : good_block());
      end else if (kind < 5) begin
        repeat ($urandom_range(1, 8)) do_alloc();
      end else if (kind < 8) begin
        // host reloads a chained block, then allocates from it
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(9, STACK_DEPTH) : $urandom_range(1, 8);
        do_refill_count(($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(n));
        for (int i = 0; i < n; i++)
          do_refill_entry(5'(i), ($urandom_range(0, 9) == 0) ? 16'h0 : good_block());
        repeat ($urandom_range(1, n + 2)) do_alloc();
      end else begin
        repeat ($urandom_range(1, 4))
          issue(fbsa_pkg::op_e'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                5'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back(input int item_goal);
    int first_data;
    idling_on = 1'b0;
    first_data = $urandom_range(0, 300);
    set_layout(16'(first_data), 16'($urandom_range(first_data + 64, 65535)));
    test_mixed_traffic(item_goal);
  endtask

  // Receiver stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 11);
    end
  end

  always @(posedge clk_i) begin : result_check
    fbsa_pkg::res_t want;
    fbsa_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status      = fbsa_pkg::status_e'(m_axis_tuser[1:0]);
      got.blk         = m_axis_tdata[15:0];
      got.refill      = m_axis_tdata[16];
      got.spill_valid = m_axis_tuser[2];
      got.spill_word  = m_axis_tdata[32:17];
      got.last        = m_axis_tlast;
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result st=%0d blk=%h rf=%b sv=%b sw=%h last=%b", $realtime,
                   got.status, got.blk, got.refill, got.spill_valid, got.spill_word, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: mismatch, want st=%0d blk=%h rf=%b sv=%b sw=%h last=%b", $realtime,
                     want.status, want.blk, want.refill, want.spill_valid, want.spill_word,
                     want.last);
            $display("%0t:            got st=%0d blk=%h rf=%b sv=%b sw=%h last=%b", $realtime,
                     got.status, got.blk, got.refill, got.spill_valid, got.spill_word, got.last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_layout();
    test_single_ops();
    test_spill_run();
    set_layout(16'd16, 16'd4096);
    test_mixed_traffic(50);
    set_layout(16'h0000, 16'hFFFF);
    test_mixed_traffic(50);
    set_layout(16'd1000, 16'd1100);
    test_mixed_traffic(40);
    test_back_to_back(25);
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("tb_top: %0d requests over %0d volume layouts, %0d results compared",
             items_sent, layouts_used, results_checked);
    $display("tb_top: %0d spill runs, %0d chained-block reloads, %0d mismatches",
             spill_runs, reload_requests, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
